[src/psit_pkg.sv]
// shared types, codes and helpers for the processor slot insertion table
// depends on nothing
package psit_pkg;

   localparam int unsigned PROCS_DEF     = 8;
   localparam int unsigned SLOTS_DEF     = 16;
   localparam int unsigned TASKS_DEF     = 256;
   localparam int unsigned TIME_BITS_DEF = 32;

   typedef enum logic [1:0] {
      OP_PROBE  = 2'd0,
      OP_PLACE  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  task_id;
      logic [2:0]  proc_index;
      logic [31:0] ready_time;
      logic [31:0] exec_time;
   } req_type;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] finish_time;
      status_type  status;
   } rsp_type;

   // remainder of a narrow value by a constant, restoring compare and subtract
   function automatic logic [7:0] mod_u8(input logic [7:0] value, input int unsigned m);
      logic [31:0] rem;
      logic [31:0] step;
      rem = {24'd0, value};
      for (int b = 7; b >= 0; b--) begin
         step = m << b;
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[7:0];
   endfunction

endpackage

[src/psit_slot_ram.sv]
// slot memory: start, finish and task id of every listed entry
// one read port with registered data, one write port; no package use
module psit_slot_ram #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW    = 7,
   parameter int unsigned TB    = 32,
   parameter int unsigned TW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [TB-1:0] rd_start,
   output logic [TB-1:0] rd_finish,
   output logic [TW-1:0] rd_task,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [TB-1:0] wr_start,
   input  logic [TB-1:0] wr_finish,
   input  logic [TW-1:0] wr_task
);

   logic [TB-1:0] start_mem  [DEPTH];
   logic [TB-1:0] finish_mem [DEPTH];
   logic [TW-1:0] task_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr]  <= wr_start;
         finish_mem[wr_addr] <= wr_finish;
         task_mem[wr_addr]   <= wr_task;
      end
      if (rd_en) begin
         rd_start  <= start_mem[rd_addr];
         rd_finish <= finish_mem[rd_addr];
         rd_task   <= task_mem[rd_addr];
      end
   end

endmodule

[src/psit_task_ram.sv]
// per task binding: processor memory with registered read, placed flags
// no package use
module psit_task_ram #(
   parameter int unsigned TASKS = 256,
   parameter int unsigned TW    = 8,
   parameter int unsigned PW    = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [TW-1:0] addr,
   input  logic          rd_en,
   output logic [PW-1:0] rd_proc,
   output logic          placed,
   input  logic          bind_en,
   input  logic [PW-1:0] bind_proc,
   input  logic          unbind_en
);

   logic [PW-1:0]    proc_mem [TASKS];
   logic [TASKS-1:0] placed_ff;
   logic [TASKS-1:0] placed_in;

   always_ff @(posedge clock) begin
      if (bind_en) begin
         proc_mem[addr] <= bind_proc;
      end
      if (rd_en) begin
         rd_proc <= proc_mem[addr];
      end
   end

   always_comb begin
      placed_in = placed_ff;
      if (bind_en) begin
         placed_in[addr] = 1'b1;
      end else if (unbind_en) begin
         placed_in[addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff <= '0;
      end else begin
         placed_ff <= placed_in;
      end
   end

   assign placed = placed_ff[addr];

endmodule

[src/processor_slot_insertion_table.sv]
// processor slot insertion table, top level: sequencer, list counts, result register
// depends on psit_pkg, psit_slot_ram, psit_task_ram
//
// usage
//   req channel: one transfer per operation (probe, place, remove, no-op).
//   rsp channel: exactly one transfer per request, in request order.
//   req_stall is high while an operation runs; one operation at a time.
//   a probe or place walks the processor list one entry per cycle through the
//   single slot memory read port.
//   a place then shifts entries up one per cycle from the list tail down to the
//   insertion point.
//   a remove reads the task binding, then compacts the list.
//   the result sits in an output register; the next request is taken once it
//   is loaded, and while rsp_stall is high a finished result waits there.
//   reset empties every processor list and forgets every task binding; no
//   clearing pass is needed.
module processor_slot_insertion_table #(
   parameter int unsigned PROCS     = psit_pkg::PROCS_DEF,
   parameter int unsigned SLOTS     = psit_pkg::SLOTS_DEF,
   parameter int unsigned TASKS     = psit_pkg::TASKS_DEF,
   parameter int unsigned TIME_BITS = psit_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psit_pkg::rsp_type rsp_data
);

   localparam int unsigned TB    = TIME_BITS;
   localparam int unsigned PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int unsigned TW    = $clog2(TASKS);
   localparam int unsigned SW    = $clog2(SLOTS);
   localparam int unsigned CW    = $clog2(SLOTS + 1);
   localparam int unsigned DEPTH = PROCS * SLOTS;
   localparam int unsigned AW    = $clog2(DEPTH);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_LOAD     = 9'b000000010,
      S_SCAN     = 9'b000000100,
      S_FIN      = 9'b000001000,
      S_INS_EVAL = 9'b000010000,
      S_INS_HEAD = 9'b000100000,
      S_TPROC    = 9'b001000000,
      S_DEL      = 9'b010000000,
      S_OUT      = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   psit_pkg::opcode_type op_ff, op_in;
   logic [TW-1:0]        task_ff, task_in;
   logic [PW-1:0]        proc_ff, proc_in;
   logic [TB-1:0]        ready_ff, ready_in;
   logic [TB-1:0]        exec_ff, exec_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        ev_ff, ev_in;
   logic [CW-1:0]        wp_ff, wp_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 found_ff, found_in;
   logic [TB-1:0]        prev_ff, prev_in;
   logic [TB-1:0]        s_ff, s_in;
   logic [TB-1:0]        f_ff, f_in;
   psit_pkg::status_type st_ff, st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   psit_pkg::rsp_type    rsp_ff, rsp_in;
   logic [CW-1:0]        cnt_ff [PROCS];
   logic [CW-1:0]        cnt_in;
   logic                 cnt_we;

   logic [CW-1:0] n_cur;
   logic [AW-1:0] base;
   logic          rd_en;
   logic [CW-1:0] rd_idx;
   logic [TB-1:0] rd_start, rd_finish;
   logic [TW-1:0] rd_task;
   logic          wr_en;
   logic [CW-1:0] wr_idx;
   logic          wr_new;
   logic [TB-1:0] wr_start, wr_finish;
   logic [TW-1:0] wr_task;
   logic          t_rd_en, bind_en, unbind_en, placed;
   logic [PW-1:0] t_rd_proc;

   logic [TB-1:0] gap;
   logic          hit, found_new, last;
   logic [TB:0]   sum;
   logic [CW-1:0] ev_next, wp_next;

   assign n_cur = cnt_ff[proc_ff];
   assign base  = AW'(AW'(proc_ff) * AW'(SLOTS));

   psit_slot_ram #(.DEPTH(DEPTH), .AW(AW), .TB(TB), .TW(TW)) u_slot_ram (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr   (base + AW'(rd_idx[SW-1:0])),
      .rd_start  (rd_start),
      .rd_finish (rd_finish),
      .rd_task   (rd_task),
      .wr_en     (wr_en),
      .wr_addr   (base + AW'(wr_idx[SW-1:0])),
      .wr_start  (wr_start),
      .wr_finish (wr_finish),
      .wr_task   (wr_task)
   );

   psit_task_ram #(.TASKS(TASKS), .TW(TW), .PW(PW)) u_task_ram (
      .clock     (clock),
      .reset     (reset),
      .addr      (task_ff),
      .rd_en     (t_rd_en),
      .rd_proc   (t_rd_proc),
      .placed    (placed),
      .bind_en   (bind_en),
      .bind_proc (proc_ff),
      .unbind_en (unbind_en)
   );

   assign wr_start  = wr_new ? s_ff    : rd_start;
   assign wr_finish = wr_new ? f_ff    : rd_finish;
   assign wr_task   = wr_new ? task_ff : rd_task;

   assign gap       = rd_start - prev_ff;
   assign hit       = found_ff && (gap >= exec_ff);
   assign found_new = found_ff || (rd_finish > ready_ff);
   assign ev_next   = ev_ff + 1'b1;
   assign last      = (ev_next == n_cur);
   assign sum       = {1'b0, s_ff} + {1'b0, exec_ff};
   assign wp_next   = wp_ff + 1'b1;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      task_in      = task_ff;
      proc_in      = proc_ff;
      ready_in     = ready_ff;
      exec_in      = exec_ff;
      idx_in       = idx_ff;
      ev_in        = ev_ff;
      wp_in        = wp_ff;
      rd_vld_in    = 1'b0;
      found_in     = found_ff;
      prev_in      = prev_ff;
      s_in         = s_ff;
      f_in         = f_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_we       = 1'b0;
      cnt_in       = n_cur;
      rd_en        = 1'b0;
      rd_idx       = idx_ff;
      wr_en        = 1'b0;
      wr_idx       = idx_ff;
      wr_new       = 1'b0;
      t_rd_en      = 1'b0;
      bind_en      = 1'b0;
      unbind_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.opcode;
               task_in  = TW'(psit_pkg::mod_u8(req_data.task_id, TASKS));
               proc_in  = PW'(psit_pkg::mod_u8({5'd0, req_data.proc_index}, PROCS));
               ready_in = TB'(req_data.ready_time);
               exec_in  = TB'(req_data.exec_time);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            idx_in   = '0;
            ev_in    = '0;
            wp_in    = '0;
            found_in = 1'b0;
            st_in    = psit_pkg::STAT_OK;
            s_in     = '0;
            f_in     = '0;
            unique case (op_ff)
               psit_pkg::OP_PROBE, psit_pkg::OP_PLACE: begin
                  if (n_cur == '0) begin
                     s_in     = ready_ff;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               psit_pkg::OP_REMOVE: begin
                  if (!placed) begin
                     st_in    = psit_pkg::STAT_NOTFOUND;
                     state_in = S_OUT;
                  end else begin
                     t_rd_en  = 1'b1;
                     state_in = S_TPROC;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCAN: begin
            if (idx_ff < n_cur) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (hit) begin
                  s_in     = prev_ff;
                  state_in = S_FIN;
               end else begin
                  found_in = found_new;
                  prev_in  = found_new ? rd_finish : prev_ff;
                  ev_in    = ev_next;
                  if (last) begin
                     s_in     = found_new ? rd_finish : ready_ff;
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_FIN: begin
            rd_idx = n_cur - 1'b1;
            idx_in = n_cur;
            if (sum[TB]) begin
               f_in     = '1;
               st_in    = psit_pkg::STAT_OVERFLOW;
               state_in = S_OUT;
            end else begin
               f_in = sum[TB-1:0];
               if (op_ff == psit_pkg::OP_PLACE) begin
                  if (n_cur >= CW'(SLOTS)) begin
                     st_in    = psit_pkg::STAT_FULL;
                     state_in = S_OUT;
                  end else begin
                     bind_en = 1'b1;
                     if (n_cur == '0) begin
                        state_in = S_INS_HEAD;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_INS_EVAL;
                     end
                  end
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_INS_EVAL: begin
            rd_idx = idx_ff - 2'd2;
            wr_en  = 1'b1;
            wr_idx = idx_ff;
            if (rd_finish <= s_ff) begin
               wr_new   = 1'b1;
               cnt_we   = 1'b1;
               cnt_in   = n_cur + 1'b1;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff - 1'b1;
               if (idx_ff == CW'(1)) begin
                  state_in = S_INS_HEAD;
               end else begin
                  rd_en = 1'b1;
               end
            end
         end
         S_INS_HEAD: begin
            wr_en    = 1'b1;
            wr_idx   = '0;
            wr_new   = 1'b1;
            cnt_we   = 1'b1;
            cnt_in   = n_cur + 1'b1;
            state_in = S_OUT;
         end
         S_TPROC: begin
            proc_in   = t_rd_proc;
            unbind_en = 1'b1;
            state_in  = S_DEL;
         end
         S_DEL: begin
            wr_idx = wp_ff;
            if (n_cur == '0) begin
               state_in = S_OUT;
            end else begin
               if (idx_ff < n_cur) begin
                  rd_en     = 1'b1;
                  rd_vld_in = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
               if (rd_vld_ff) begin
                  ev_in = ev_next;
                  if (rd_task != task_ff) begin
                     wr_en = 1'b1;
                     wp_in = wp_next;
                  end
                  if (last) begin
                     cnt_we   = 1'b1;
                     cnt_in   = (rd_task != task_ff) ? wp_next : wp_ff;
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.start_time  = 32'(s_ff);
               rsp_in.finish_time = 32'(f_ff);
               rsp_in.status      = st_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         for (int i = 0; i < int'(PROCS); i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         if (cnt_we) begin
            cnt_ff[proc_ff] <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      task_ff  <= task_in;
      proc_ff  <= proc_in;
      ready_ff <= ready_in;
      exec_ff  <= exec_in;
      idx_ff   <= idx_in;
      ev_ff    <= ev_in;
      wp_ff    <= wp_in;
      found_ff <= found_in;
      prev_ff  <= prev_in;
      s_ff     <= s_in;
      f_ff     <= f_in;
      st_ff    <= st_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
